// ----- rtl/ofim_pkg.sv -----
// Shared types and constants for the OFDM frequency-interleave map.
package ofim_pkg;

	typedef enum logic [0:0] {
		ST_IDLE,
		ST_BUILD
	} state_t;

	typedef enum logic [1:0] {
		REG_SIZE_LOG2   = 2'd0,
		REG_INCREMENT   = 2'd1,
		REG_LOWER_BOUND = 2'd2,
		REG_UPPER_BOUND = 2'd3
	} reg_index_t;

	localparam logic [0:0] OP_REBUILD = 1'b0;
	localparam logic [0:0] OP_LOOKUP  = 1'b1;

	localparam int          MIN_SIZE_LOG2 = 8;
	localparam logic [3:0]  MULTIPLIER    = 4'd13;

	localparam int OFFSET_W = 11;
	localparam int COUNT_W  = 12;
	localparam int INDEX_W  = 11;
	localparam int CFG_W    = 12;

	localparam logic [3:0]  RST_SIZE_LOG2   = 4'd11;
	localparam logic [10:0] RST_INCREMENT   = 11'd511;
	localparam logic [10:0] RST_LOWER_BOUND = 11'd256;
	localparam logic [11:0] RST_UPPER_BOUND = 12'd1792;

endpackage

// ----- rtl/ofim_ram.sv -----
// Generic simple dual-port RAM with registered read.
module ofim_ram #(
	parameter int WIDTH = 11,
	parameter int DEPTH = 2048
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[wr_addr] <= wr_data;
		end
		rd_data <= mem_q[rd_addr];
	end

endmodule

// ----- rtl/ofdm_frequency_interleave_map.sv -----
// A lookup returns its beat in the cycle after start; a new lookup every cycle when idle.
// A rebuild walks T = 2^eff_log2 generator steps, one per cycle, writing the table RAM;
// eff_log2 clamps size_log2 to 8..MAX_SIZE_LOG2; busy spans the steps, then done pulses.
// Results are one-cycle strobes on done; the receiver cannot stall.
// arst_n clears the entry count and control; registers return to their RST_ values.
// The table RAM is not cleared: lookups are gated by the entry count.
module ofdm_frequency_interleave_map #(
	parameter int MAX_SIZE_LOG2 = 11
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic [0:0]                    operation,
	input  logic [ofim_pkg::INDEX_W-1:0]  index,
	input  logic                          cfg_we,
	input  logic [1:0]                    cfg_index,
	input  logic [ofim_pkg::CFG_W-1:0]    cfg_data,
	output logic                          done,
	output logic signed [ofim_pkg::OFFSET_W-1:0] carrier_offset,
	output logic [ofim_pkg::COUNT_W-1:0]  entry_count,
	output logic                          in_range
);
	import ofim_pkg::*;

	localparam int AW    = MAX_SIZE_LOG2;
	localparam int DEPTH = 1 << MAX_SIZE_LOG2;
	localparam int CNT_W = MAX_SIZE_LOG2 + 1;
	localparam int SUM_W = MAX_SIZE_LOG2 + 5;
	localparam int DIF_W = (MAX_SIZE_LOG2 > OFFSET_W) ? MAX_SIZE_LOG2 : OFFSET_W;
	localparam int BND_W = (MAX_SIZE_LOG2 > COUNT_W) ? MAX_SIZE_LOG2 : COUNT_W;
	localparam int IDX_W = (CNT_W > INDEX_W) ? CNT_W : INDEX_W;

	// configuration
	logic [3:0]  size_log2_q;
	logic [10:0] increment_q;
	logic [10:0] lower_bound_q;
	logic [11:0] upper_bound_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			size_log2_q   <= RST_SIZE_LOG2;
			increment_q   <= RST_INCREMENT;
			lower_bound_q <= RST_LOWER_BOUND;
			upper_bound_q <= RST_UPPER_BOUND;
		end else if (cfg_we) begin
			unique case (reg_index_t'(cfg_index))
				REG_SIZE_LOG2:   size_log2_q   <= cfg_data[3:0];
				REG_INCREMENT:   increment_q   <= cfg_data[10:0];
				REG_LOWER_BOUND: lower_bound_q <= cfg_data[10:0];
				REG_UPPER_BOUND: upper_bound_q <= cfg_data[11:0];
				default: ;
			endcase
		end
	end

	// effective size, mask and half
	logic [3:0]    eff_log2;
	logic [AW-1:0] mask;
	logic [AW-1:0] half;

	always_comb begin
		eff_log2 = size_log2_q;
		if (size_log2_q < 4'(MIN_SIZE_LOG2)) begin
			eff_log2 = 4'(MIN_SIZE_LOG2);
		end
		if (size_log2_q > 4'(MAX_SIZE_LOG2)) begin
			eff_log2 = 4'(MAX_SIZE_LOG2);
		end
		mask = {AW{1'b1}} >> (4'(MAX_SIZE_LOG2) - eff_log2);
		half = (mask >> 1) + AW'(1);
	end

	// control
	state_t state_q, state_d;
	logic   accept;
	logic   build_active;
	logic   last_step;

	logic [AW-1:0]    x_q;
	logic [AW-1:0]    step_q;
	logic [CNT_W-1:0] count_q;
	logic             done_q;
	logic             hit_q;

	assign accept    = start && !busy;
	assign last_step = (step_q == mask);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:  if (accept && operation == OP_REBUILD) state_d = ST_BUILD;
			ST_BUILD: if (last_step) state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		busy         = 1'b0;
		build_active = 1'b0;
		unique case (state_q)
			ST_IDLE:  ;
			ST_BUILD: begin
				busy         = 1'b1;
				build_active = 1'b1;
			end
			default:  ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// generator step
	logic [SUM_W-1:0] x_sum;
	logic [AW-1:0]    x_next;
	logic             keep;
	logic [DIF_W-1:0] x_diff;

	always_comb begin
		x_sum  = SUM_W'(x_q) * SUM_W'(MULTIPLIER) + SUM_W'(increment_q);
		x_next = x_sum[AW-1:0] & mask;
		keep   = (x_q != half)
		      && (BND_W'(x_q) >= BND_W'(lower_bound_q))
		      && (BND_W'(x_q) <= BND_W'(upper_bound_q));
		x_diff = DIF_W'(x_q) - DIF_W'(half);
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			x_q    <= '0;
			step_q <= '0;
		end else if (build_active) begin
			x_q    <= x_next;
			step_q <= step_q + AW'(1);
		end
	end

	// lookup gate
	logic lookup_hit;
	assign lookup_hit = IDX_W'(index) < IDX_W'(count_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			done_q  <= 1'b0;
			hit_q   <= 1'b0;
		end else begin
			done_q <= 1'b0;
			hit_q  <= 1'b0;
			if (accept) begin
				if (operation == OP_LOOKUP) begin
					done_q <= 1'b1;
					hit_q  <= lookup_hit;
				end else begin
					count_q <= '0;
				end
			end
			if (build_active) begin
				if (keep) count_q <= count_q + CNT_W'(1);
				if (last_step) done_q <= 1'b1;
			end
		end
	end

	// table memory
	logic [OFFSET_W-1:0] rd_data;

	ofim_ram #(
		.WIDTH (OFFSET_W),
		.DEPTH (DEPTH)
	) u_table (
		.clk     (clk),
		.we      (build_active && keep),
		.wr_addr (count_q[AW-1:0]),
		.wr_data (x_diff[OFFSET_W-1:0]),
		.rd_addr (AW'(index)),
		.rd_data (rd_data)
	);

	assign done           = done_q;
	assign in_range       = hit_q;
	assign carrier_offset = hit_q ? signed'(rd_data) : '0;
	assign entry_count    = COUNT_W'(count_q);

endmodule

// ----- rtl/ofim_check.sv -----
// Port-level assertions for the interleave map, bound to the top level.
module ofim_check (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic                          busy,
	input  logic [0:0]                    operation,
	input  logic [ofim_pkg::INDEX_W-1:0]  index,
	input  logic                          cfg_we,
	input  logic [1:0]                    cfg_index,
	input  logic [ofim_pkg::CFG_W-1:0]    cfg_data,
	input  logic                          done,
	input  logic signed [ofim_pkg::OFFSET_W-1:0] carrier_offset,
	input  logic [ofim_pkg::COUNT_W-1:0]  entry_count,
	input  logic                          in_range
);
	import ofim_pkg::*;

	// a lookup beat always follows in the next cycle
	a_lookup_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && operation == OP_LOOKUP) |=> done)
		else $error("lookup beat missing");

	a_rebuild_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && operation == OP_REBUILD) |=> (busy && !done))
		else $error("rebuild did not hold busy");

	a_no_beat_while_busy: assert property (@(posedge clk) disable iff (!arst_n)
		busy |-> !done)
		else $error("result beat during rebuild");

	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && !in_range) |-> (carrier_offset == '0))
		else $error("nonzero offset on miss");

	a_hit_below_count: assert property (@(posedge clk) disable iff (!arst_n)
		(done && in_range) |-> ({1'b0, $past(index)} < entry_count))
		else $error("hit with index at or beyond count");

	logic unused_cfg;
	assign unused_cfg = cfg_we ^ (|cfg_index) ^ (|cfg_data);

endmodule

bind ofdm_frequency_interleave_map ofim_check u_check (.*);
